@@ design/apq_pkg.sv @@
// Package: shared types and constants of the aging priority ready queue.
`default_nettype none
package apq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int LEN_W       = 10;
  localparam int SCORE_W     = 10;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_AGE = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_WALK,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_W-1:0]    process_id;
    logic [LEN_W-1:0]   job_length;
    logic [SCORE_W-1:0] initial_score;
  } item_t;

  typedef struct packed {
    logic            popped_valid;
    logic [ID_W-1:0] popped_id;
    logic            queue_empty;
    logic            dropped_full;
    logic [CNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

endpackage
`default_nettype wire

@@ design/apq_if.sv @@
// Interfaces: input, result and configuration channels of the queue.
`default_nettype none
interface apq_in_if import apq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ID_W-1:0]    process_id;
  logic [LEN_W-1:0]   job_length;
  logic [SCORE_W-1:0] initial_score;

  modport source (output valid, operation, process_id, job_length, initial_score,
                  input ready);
  modport sink (input valid, operation, process_id, job_length, initial_score,
                output ready);
endinterface

interface apq_out_if import apq_pkg::*;;
  logic             valid;
  logic             ready;
  logic             popped_valid;
  logic [ID_W-1:0]  popped_id;
  logic             queue_empty;
  logic             dropped_full;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, popped_valid, popped_id, queue_empty, dropped_full,
                  entry_count, input ready);
  modport sink (input valid, popped_valid, popped_id, queue_empty, dropped_full,
                entry_count, output ready);
endinterface

interface apq_cfg_if;
  logic valid;
  logic ready;
  logic ordering_mode;

  modport source (output valid, ordering_mode, input ready);
  modport sink (input valid, ordering_mode, output ready);
endinterface
`default_nettype wire

@@ design/apq_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module apq_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 28
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/apq_ctrl.sv @@
// Sequencer: walks the entry memory to insert, remove, age and promote entries.
`default_nettype none
module apq_ctrl import apq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     mode,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire item_t    in_item,
  output logic          res_valid,
  input  wire logic     res_ready,
  output result_t       res,
  output mem_req_t      mem_req,
  input  wire entry_t   mem_rdata
);

  state_t           state, state_next;
  op_t              op, op_next;
  entry_t           cur, cur_next;
  entry_t           head, head_next;
  entry_t           dec;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] ri, ri_next, ri_adv;
  logic             rd_on, rd_on_next, rd_on_adv;
  logic [IDX_W-1:0] last, last_next;
  logic             down, down_next;
  logic             pv, pv_next;
  logic [IDX_W-1:0] pidx, pidx_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic             promoting, promoting_next;
  logic             popped_v, popped_v_next;
  logic             dropped, dropped_next;
  logic             reread;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rd_on     <= 1'b0;
      pv        <= 1'b0;
      promoting <= 1'b0;
      popped_v  <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rd_on     <= rd_on_next;
      pv        <= pv_next;
      promoting <= promoting_next;
      popped_v  <= popped_v_next;
      dropped   <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    cur  <= cur_next;
    head <= head_next;
    ri   <= ri_next;
    last <= last_next;
    down <= down_next;
    pidx <= pidx_next;
    pos  <= pos_next;
  end

  always_comb begin
    dec       = mem_rdata;
    dec.score = mem_rdata.score - SCORE_W'(mem_rdata.score != '0);
    rd_on_adv = rd_on && (ri != last);
    ri_adv    = down ? ri - 1'b1 : ri + 1'b1;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cur_next       = cur;
    head_next      = head;
    cnt_next       = cnt;
    ri_next        = ri;
    rd_on_next     = rd_on;
    last_next      = last;
    down_next      = down;
    pv_next        = pv;
    pidx_next      = pidx;
    pos_next       = pos;
    promoting_next = promoting;
    popped_v_next  = popped_v;
    dropped_next   = dropped;
    reread         = 1'b0;
    in_ready       = (state == ST_IDLE);
    res_valid      = (state == ST_DONE);
    mem_req.re     = rd_on;
    mem_req.raddr  = ri;
    mem_req.we     = 1'b0;
    mem_req.waddr  = pidx;
    mem_req.wdata  = mem_rdata;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next        = op_t'(in_item.operation);
          cur_next.id    = in_item.process_id;
          cur_next.len   = in_item.job_length;
          cur_next.score = in_item.initial_score;
          popped_v_next  = 1'b0;
          dropped_next   = 1'b0;
          promoting_next = 1'b0;
          pv_next        = 1'b0;
          down_next      = 1'b0;
          ri_next        = '0;
          last_next      = IDX_W'(cnt - 1'b1);
          unique case (op_t'(in_item.operation))
            OP_ENQ: begin
              if (cnt == CNT_W'(QUEUE_DEPTH)) begin
                dropped_next = 1'b1;
                state_next   = ST_DONE;
              end else if (!mode || cnt == '0) begin
                pos_next   = IDX_W'(cnt);
                state_next = ST_FINAL;
              end else begin
                rd_on_next = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_DEQ: begin
              if (cnt == '0) begin
                state_next = ST_DONE;
              end else begin
                rd_on_next = 1'b1;
                state_next = ST_WALK;
              end
            end
            OP_AGE: begin
              if (cnt < CNT_W'(2)) begin
                state_next = ST_DONE;
              end else begin
                rd_on_next = 1'b1;
                state_next = ST_WALK;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        pv_next    = rd_on;
        pidx_next  = ri;
        ri_next    = ri_adv;
        rd_on_next = rd_on_adv;
        if (pv) begin
          if (mem_rdata.len > cur.len) begin
            pos_next   = pidx;
            ri_next    = IDX_W'(cnt - 1'b1);
            last_next  = pidx;
            down_next  = 1'b1;
            rd_on_next = 1'b1;
            pv_next    = 1'b0;
            state_next = ST_SHIFT;
          end else if (pidx == last) begin
            pos_next   = IDX_W'(cnt);
            state_next = ST_FINAL;
          end
        end
      end

      ST_SHIFT: begin
        pv_next    = rd_on;
        pidx_next  = ri;
        ri_next    = ri_adv;
        rd_on_next = rd_on_adv;
        if (pv) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pidx + 1'b1;
          if (pidx == pos) begin
            state_next = ST_FINAL;
          end
        end
      end

      ST_WALK: begin
        pv_next    = rd_on;
        pidx_next  = ri;
        ri_next    = ri_adv;
        rd_on_next = rd_on_adv;
        if (pv) begin
          if (pidx == '0) begin
            head_next = mem_rdata;
          end else if (op == OP_DEQ) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pidx - 1'b1;
          end else if (pidx == IDX_W'(1)) begin
            mem_req.we    = 1'b1;
            mem_req.wdata = dec;
            if (head.score > dec.score) begin
              promoting_next = 1'b1;
              mem_req.waddr  = '0;
            end
          end else if (promoting) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pidx - 1'b1;
            if (dec.score <= head.score) begin
              mem_req.wdata = dec;
            end else begin
              mem_req.wdata  = head;
              promoting_next = 1'b0;
              reread         = 1'b1;
              ri_next        = pidx;
              rd_on_next     = 1'b1;
              pv_next        = 1'b0;
            end
          end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = dec;
          end
          if (pidx == last && !reread) begin
            state_next = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        state_next = ST_DONE;
        unique case (op)
          OP_ENQ: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos;
            mem_req.wdata = cur;
            cnt_next      = cnt + 1'b1;
          end
          OP_DEQ: begin
            popped_v_next = 1'b1;
            cnt_next      = cnt - 1'b1;
          end
          OP_AGE: begin
            mem_req.we    = promoting;
            mem_req.waddr = IDX_W'(cnt - 1'b1);
            mem_req.wdata = head;
          end
          default: begin
          end
        endcase
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.popped_valid = popped_v;
    res.popped_id    = popped_v ? head.id : '0;
    res.queue_empty  = (cnt == '0);
    res.dropped_full = dropped;
    res.entry_count  = cnt;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.dropped_full |-> res.entry_count == CNT_W'(QUEUE_DEPTH))
    else $error("drop reported on a queue that is not full");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINAL && op == OP_DEQ |=> cnt == CNT_W'($past(cnt) - 1'b1))
    else $error("dequeue did not lower the count by one");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> CNT_W'(mem_req.waddr) <= cnt)
    else $error("memory write beyond the occupied range");

  a_pipe_state: assert property (@(posedge clk) disable iff (rst)
    pv |-> state == ST_SCAN || state == ST_SHIFT || state == ST_WALK)
    else $error("read data pending outside a memory walk");
`endif

endmodule
`default_nettype wire

@@ design/aging_priority_ready_queue_top.sv @@
// Top level: aging priority ready queue with configuration and result registers.
// From accept to result valid: ignored operations, drops, empty dequeues and short age
// ticks go straight to the result; FIFO enqueue writes the entry in one final step;
// sorted enqueue, dequeue and age tick first walk the entries held, then do that step.
// Throughput: one transaction at a time; the next input is taken in the cycle after the
// result leaves the sequencer; the walk reads one entry per cycle, bar a re-read.
`default_nettype none
module aging_priority_ready_queue_top import apq_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  apq_in_if.sink    in_ch,
  apq_out_if.source out_ch,
  apq_cfg_if.sink   cfg_ch
);

  logic     mode;
  logic     res_valid;
  logic     res_ready;
  logic     in_ready;
  result_t  res;
  result_t  out_res;
  logic     out_valid;
  item_t    in_item;
  mem_req_t mem_req;
  logic [$bits(entry_t)-1:0] ram_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_ch.valid) begin
      mode <= cfg_ch.ordering_mode;
    end
  end

  always_comb begin
    in_item.operation     = in_ch.operation;
    in_item.process_id    = in_ch.process_id;
    in_item.job_length    = in_ch.job_length;
    in_item.initial_score = in_ch.initial_score;
  end

  assign in_ch.ready = in_ready;

  apq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (entry_t'(ram_rdata))
  );

  apq_ram #(
    .ADDR_W (IDX_W),
    .DATA_W ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata)
  );

  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.popped_valid = out_res.popped_valid;
  assign out_ch.popped_id    = out_res.popped_id;
  assign out_ch.queue_empty  = out_res.queue_empty;
  assign out_ch.dropped_full = out_res.dropped_full;
  assign out_ch.entry_count  = out_res.entry_count;

endmodule
`default_nettype wire
